>>> design/gas_pkg.sv
package gas_pkg;

  // Default geometry of the atlas
  localparam int PAGE_SIZE_DEF = 1024;
  localparam int MAX_PAGES_DEF = 8;

  typedef enum logic [1:0] {
    CMD_PLACE = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_PLACED  = 3'd0,
    STS_TOO_BIG = 3'd1,
    STS_NO_PAGE = 3'd2,
    STS_DIRTY   = 3'd3,
    STS_CLEAN   = 3'd4,
    STS_MARKED  = 3'd5
  } stat_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_RUN  = 1'b1
  } fsm_t;

  // Command token walking down the page cells
  typedef struct packed {
    logic       valid;
    cmd_t       cmd;
    logic [9:0] w;
    logic [9:0] h;
    logic       done;
    logic       big;
  } tok_t;

  // One result beat
  typedef struct packed {
    stat_t       status;
    logic [2:0]  page;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [10:0] rect_left;
    logic [10:0] rect_top;
    logic [10:0] rect_right;
    logic [10:0] rect_bottom;
    logic        last;
  } beat_t;

endpackage

>>> design/gas_cell.sv
module gas_cell #(
  parameter int PAGE_SIZE = gas_pkg::PAGE_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          cell_first,
  input  gas_pkg::tok_t tok_in,
  output gas_pkg::tok_t tok_out,
  output logic          res_valid,
  output gas_pkg::beat_t res
);
  import gas_pkg::*;

  localparam int CW = $clog2(PAGE_SIZE) + 2;
  localparam logic [CW-1:0] LIM  = CW'(PAGE_SIZE - 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] SIZE = CW'(PAGE_SIZE);

  logic          used_r, used_nxt;
  logic [CW-1:0] pen_col_r, pen_col_nxt;
  logic [CW-1:0] pen_row_r, pen_row_nxt;
  logic [CW-1:0] row_bot_r, row_bot_nxt;
  logic          dirty_r, dirty_nxt;
  logic [CW-1:0] dl_r, dl_nxt, dt_r, dt_nxt, dr_r, dr_nxt, db_r, db_nxt;
  tok_t          tok_r, tok_nxt;

  logic [CW-1:0] wc, hc, eff_col, eff_row, rb1, ny, px, py, yh;
  logic [CW-1:0] xl, yt, xr, yb;
  logic          fit_cur, fit_new, here, do_place, do_flush, do_mark;
  logic [15:0]   px16, py16, l16, t16, r16, b16;

  // Fit checks at the pen and on a new row
  always_comb begin
    wc      = CW'(tok_in.w);
    hc      = CW'(tok_in.h);
    eff_col = (pen_col_r == '0 || pen_row_r == '0) ? ONE : pen_col_r;
    eff_row = (pen_col_r == '0 || pen_row_r == '0) ? ONE : pen_row_r;
    rb1     = row_bot_r + ONE;
    ny      = (eff_row > rb1) ? eff_row : rb1;
    fit_cur = ((eff_col + wc) < LIM) && ((eff_row + hc) < LIM);
    fit_new = ((ONE + wc) < LIM) && ((ny + hc) < LIM);
    px      = fit_cur ? eff_col : ONE;
    py      = fit_cur ? eff_row : ny;
    yh      = py + hc;
    xl      = px - ONE;
    yt      = py - ONE;
    xr      = px + wc + ONE;
    yb      = yh + ONE;
  end

  // Decide what this page does with the passing token
  always_comb begin
    here     = tok_in.valid && step;
    do_place = here && (tok_in.cmd == CMD_PLACE) && !tok_in.done && !tok_in.big
               && (fit_cur || fit_new);
    do_flush = here && (tok_in.cmd == CMD_FLUSH) && used_r && dirty_r;
    do_mark  = here && (tok_in.cmd == CMD_MARK) && used_r;
  end

  // Page state update
  always_comb begin
    used_nxt    = used_r;
    pen_col_nxt = pen_col_r;
    pen_row_nxt = pen_row_r;
    row_bot_nxt = row_bot_r;
    dirty_nxt   = dirty_r;
    dl_nxt      = dl_r;
    dt_nxt      = dt_r;
    dr_nxt      = dr_r;
    db_nxt      = db_r;
    if (do_place) begin
      used_nxt    = 1'b1;
      pen_col_nxt = xr;
      pen_row_nxt = py;
      row_bot_nxt = (yh > row_bot_r) ? yh : row_bot_r;
      dirty_nxt   = 1'b1;
      if (dirty_r) begin
        dl_nxt = (xl < dl_r) ? xl : dl_r;
        dt_nxt = (yt < dt_r) ? yt : dt_r;
        dr_nxt = (xr > dr_r) ? xr : dr_r;
        db_nxt = (yb > db_r) ? yb : db_r;
      end else begin
        dl_nxt = xl;
        dt_nxt = yt;
        dr_nxt = xr;
        db_nxt = yb;
      end
    end
    if (do_flush) begin
      dirty_nxt = 1'b0;
    end
    if (do_mark) begin
      dirty_nxt = 1'b1;
      dl_nxt    = '0;
      dt_nxt    = '0;
      dr_nxt    = SIZE;
      db_nxt    = rb1;
    end
  end

  // Advance the token, flag it once placed
  always_comb begin
    tok_nxt = tok_r;
    if (step) begin
      tok_nxt      = tok_in;
      tok_nxt.done = tok_in.done || do_place;
    end
  end

  // Result beat of this page
  always_comb begin
    px16      = 16'(px);
    py16      = 16'(py);
    l16       = 16'(dl_r);
    t16       = 16'(dt_r);
    r16       = 16'(dr_r);
    b16       = 16'(db_r);
    res_valid = do_place || do_flush;
    res       = '0;
    if (do_place) begin
      res.status = STS_PLACED;
      res.pos_x  = px16[9:0];
      res.pos_y  = py16[9:0];
    end else begin
      res.status      = STS_DIRTY;
      res.rect_left   = l16[10:0];
      res.rect_top    = t16[10:0];
      res.rect_right  = r16[10:0];
      res.rect_bottom = b16[10:0];
    end
  end

  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= cell_first;
      pen_col_r <= '0;
      pen_row_r <= '0;
      row_bot_r <= '0;
      dirty_r   <= 1'b0;
      tok_r     <= '0;
    end else begin
      used_r    <= used_nxt;
      pen_col_r <= pen_col_nxt;
      pen_row_r <= pen_row_nxt;
      row_bot_r <= row_bot_nxt;
      dirty_r   <= dirty_nxt;
      tok_r     <= tok_nxt;
    end
  end

  // Dirty rectangle, read only while dirty_r is set
  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    dt_r <= dt_nxt;
    dr_r <= dr_nxt;
    db_r <= db_nxt;
  end

endmodule

>>> design/glyph_atlas_shelf_allocator.sv
// Channel | Ports                                     | Direction
// in      | in_valid, in_stall, in_command, in_glyph_* | command beats in
// out     | out_valid, out_stall, out_status ... last  | result beats out
//
// A command is accepted into a launch register; its token then walks the
// page cells in turn and is retired at the chain end. Stalls on out hold it.
// Reset (synchronous, rst_n low) leaves all pages empty with page 0 open.
// A result beat waits in the output register while the token walks on;
// the chain holds only when that register is full and stalled.
module glyph_atlas_shelf_allocator #(
  parameter int PAGE_SIZE = gas_pkg::PAGE_SIZE_DEF,
  parameter int MAX_PAGES = gas_pkg::MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [9:0]  in_glyph_width,
  input  logic [9:0]  in_glyph_height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_page,
  output logic [9:0]  out_pos_x,
  output logic [9:0]  out_pos_y,
  output logic [10:0] out_rect_left,
  output logic [10:0] out_rect_top,
  output logic [10:0] out_rect_right,
  output logic [10:0] out_rect_bottom,
  output logic        out_last
);
  import gas_pkg::*;

  localparam int NP = MAX_PAGES;
  localparam logic [12:0] BIG_LIM = 13'(PAGE_SIZE - 3);

  fsm_t  state_r, state_nxt;
  tok_t  tok0_r, tok0_nxt;
  tok_t  tok_w [0:NP];
  tok_t  end_tok;
  logic  [NP:0] tok_vld;
  logic  res_valid [NP];
  beat_t res [NP];
  beat_t sel, pb, out_r, out_nxt, pend_r, pend_nxt;
  logic  sel_valid, push, step, accept;
  logic  out_valid_r, out_valid_nxt, pend_valid_r, pend_valid_nxt;
  cmd_t  in_cmd;
  logic  in_big;

  assign in_cmd  = cmd_t'(in_command);
  assign in_big  = (13'(in_glyph_width) > BIG_LIM) || (13'(in_glyph_height) > BIG_LIM);
  assign accept  = in_valid && !in_stall;
  assign step    = !out_valid_r || !out_stall;
  assign end_tok = tok_w[NP];
  assign tok_w[0] = tok0_r;

  // Page cells
  for (genvar k = 0; k < NP; k++) begin : g_cell
    gas_cell #(.PAGE_SIZE(PAGE_SIZE)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .cell_first (k == 0),
      .tok_in     (tok_w[k]),
      .tok_out    (tok_w[k+1]),
      .res_valid  (res_valid[k]),
      .res        (res[k])
    );
  end

  always_comb begin
    for (int k = 0; k <= NP; k++) begin
      tok_vld[k] = tok_w[k].valid;
    end
  end

  // Launch a token on accept, drop it once it moves into cell 0
  always_comb begin
    tok0_nxt = tok0_r;
    if (step) begin
      tok0_nxt.valid = 1'b0;
    end
    if (accept && in_cmd != CMD_NOP) begin
      tok0_nxt.valid = 1'b1;
      tok0_nxt.cmd   = in_cmd;
      tok0_nxt.w     = in_glyph_width;
      tok0_nxt.h     = in_glyph_height;
      tok0_nxt.done  = 1'b0;
      tok0_nxt.big   = in_big;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (accept && in_cmd != CMD_NOP) state_nxt = FSM_RUN;
      FSM_RUN:  if (step && end_tok.valid) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = (state_r != FSM_IDLE);
  end

  // Pick the one cell that answered
  always_comb begin
    sel_valid = 1'b0;
    sel       = '0;
    for (int k = 0; k < NP; k++) begin
      if (res_valid[k]) begin
        sel_valid = 1'b1;
        sel       = res[k];
        sel.page  = 3'(k);
      end
    end
  end

  // Result beats; hold one flush rectangle back to know which is last
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    push           = 1'b0;
    pb             = '0;
    if (step) begin
      if (sel_valid) begin
        if (sel.status == STS_PLACED) begin
          push    = 1'b1;
          pb      = sel;
          pb.last = 1'b1;
        end else begin
          if (pend_valid_r) begin
            push = 1'b1;
            pb   = pend_r;
          end
          pend_nxt       = sel;
          pend_valid_nxt = 1'b1;
        end
      end
      if (end_tok.valid) begin
        case (end_tok.cmd)
          CMD_PLACE: begin
            if (end_tok.big) begin
              push      = 1'b1;
              pb.status = STS_TOO_BIG;
              pb.last   = 1'b1;
            end else if (!end_tok.done) begin
              push      = 1'b1;
              pb.status = STS_NO_PAGE;
              pb.last   = 1'b1;
            end
          end
          CMD_FLUSH: begin
            push = 1'b1;
            if (pend_valid_r) begin
              pb             = pend_r;
              pend_valid_nxt = 1'b0;
            end else begin
              pb.status = STS_CLEAN;
            end
            pb.last = 1'b1;
          end
          CMD_MARK: begin
            push      = 1'b1;
            pb.status = STS_MARKED;
            pb.last   = 1'b1;
          end
          default: ;
        endcase
      end
    end
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      tok0_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tok0_r       <= tok0_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_page        = out_r.page;
  assign out_pos_x       = out_r.pos_x;
  assign out_pos_y       = out_r.pos_y;
  assign out_rect_left   = out_r.rect_left;
  assign out_rect_top    = out_r.rect_top;
  assign out_rect_right  = out_r.rect_right;
  assign out_rect_bottom = out_r.rect_bottom;
  assign out_last        = out_r.last;

  // At most one token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one command token in the chain");

  // A running command always has its token somewhere
  a_run_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_RUN) |-> (tok_vld != '0))
    else $error("command running without a token");

  // New beats come only from a running command
  a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == FSM_RUN))
    else $error("result beat with no command in flight");

  // A held flush rectangle never outlives its command
  a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == FSM_RUN))
    else $error("held dirty rectangle while idle");

endmodule
